// ===== src/krsf_pkg.sv =====
// Shared constants, codes and types of the keyed record sort, filter and total block.
package krsf_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_BYTES = 8;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = AW + 1;
    localparam int KEY_W     = 64;
    localparam int COST_W    = 32;
    localparam int CAT_W     = 2;
    localparam int TOT_W     = 40;
    localparam int STAT_W    = 2;

    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic [CW-1:0]    DEPTH_C   = CW'(DEPTH);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    localparam logic CFG_DESCENDING = 1'b0;
    localparam logic CFG_CATEGORY   = 1'b1;

    localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_REPORT   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [COST_W-1:0] cost;
        logic [CAT_W-1:0]  cat;
    } record_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // append the input record or report store full
        logic sort_init;  // outer index to one
        logic rd_prev;    // read address is j-1 instead of i
        logic hold_take;  // capture the read record, j takes i
        logic wr_shift;   // write the read record at j, step j down
        logic wr_held;    // write the held record at j, step i up
        logic scan_init;  // outer index to zero, clear total and pending item
        logic scan_take;  // filter the read record, step i up
        logic flush;      // give the final result of the report
    } krsf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic move;
    } krsf_stat_t;

endpackage

// ===== src/krsf_datapath.sv =====
// Datapath: record memory, indexes, held record, pending report item and result registers.
module krsf_datapath
    import krsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  krsf_cmd_t           cmd,
    output krsf_stat_t          stat,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CAT_W-1:0]    cfg_wdata,
    input  logic [KEY_W-1:0]    record_key,
    input  logic [COST_W-1:0]   cost_cents,
    input  logic [CAT_W-1:0]    category_code,
    output logic                result_valid,
    output logic [STAT_W-1:0]   status,
    output logic                has_record,
    output logic [KEY_W-1:0]    out_key,
    output logic [COST_W-1:0]   out_cost_cents,
    output logic [TOT_W-1:0]    running_total_cents,
    output logic                last
);

    record_t            mem [DEPTH];
    record_t            rd_data_reg;
    record_t            held_reg;
    record_t            pend_reg;
    logic               pend_valid_reg;
    logic [TOT_W-1:0]   pend_total_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic               desc_reg;
    logic [CAT_W-1:0]   cat_sel_reg;

    logic [CW-1:0]      rd_addr;
    logic [CW-1:0]      wr_addr;
    record_t            wr_data;
    logic               wr_en;
    logic [TOT_W:0]     sum;
    logic [TOT_W-1:0]   total_next;
    logic               match;

    assign rd_addr = cmd.rd_prev ? j_reg - CW'(1) : i_reg;
    assign wr_en   = (cmd.load && count_reg != DEPTH_C) || cmd.wr_shift || cmd.wr_held;
    assign wr_addr = cmd.load ? count_reg : j_reg;

    always_comb
    begin
        if (cmd.load)
        begin
            wr_data = '{key: record_key & KEY_MASK, cost: cost_cents, cat: category_code};
        end
        else if (cmd.wr_shift)
        begin
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_data = held_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign stat.i_done = (i_reg >= count_reg);
    assign stat.j_zero = (j_reg == '0);
    assign stat.move   = desc_reg ? (rd_data_reg.key < held_reg.key)
                                  : (rd_data_reg.key > held_reg.key);

    assign match      = (rd_data_reg.cat == cat_sel_reg);
    assign sum        = {1'b0, total_reg} + {{(TOT_W + 1 - COST_W){1'b0}}, rd_data_reg.cost};
    assign total_next = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.hold_take)
        begin
            held_reg <= rd_data_reg;
        end
        if (cmd.scan_take && match)
        begin
            pend_reg       <= rd_data_reg;
            pend_total_reg <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            desc_reg       <= 1'b0;
            cat_sel_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DESCENDING)
                begin
                    desc_reg <= cfg_wdata[0];
                end
                else
                begin
                    cat_sel_reg <= cfg_wdata;
                end
            end
            if (cmd.load && count_reg != DEPTH_C)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.sort_init)
            begin
                i_reg <= CW'(1);
            end
            if (cmd.hold_take)
            begin
                j_reg <= i_reg;
            end
            if (cmd.wr_shift)
            begin
                j_reg <= j_reg - CW'(1);
            end
            if (cmd.wr_held || cmd.scan_take)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.scan_init)
            begin
                i_reg          <= '0;
                total_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.scan_take && match)
            begin
                total_reg      <= total_next;
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Result registers; a matching record is shown once the next match or the end is known.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.load || cmd.flush || (cmd.scan_take && match && pend_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status              <= (count_reg == DEPTH_C) ? ST_FULL : ST_ACCEPTED;
            has_record          <= 1'b0;
            out_key             <= '0;
            out_cost_cents      <= '0;
            running_total_cents <= '0;
            last                <= 1'b1;
        end
        else if (cmd.flush || (cmd.scan_take && match && pend_valid_reg))
        begin
            status              <= ST_REPORT;
            has_record          <= pend_valid_reg;
            out_key             <= pend_valid_reg ? pend_reg.key : '0;
            out_cost_cents      <= pend_valid_reg ? pend_reg.cost : '0;
            running_total_cents <= pend_valid_reg ? pend_total_reg : '0;
            last                <= cmd.flush;
        end
    end

endmodule

// ===== src/krsf_ctrl.sv =====
// Controller: sequences loads, the insertion sort over memory and the filtered scan.
module krsf_ctrl
    import krsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        action,
    input  krsf_stat_t  stat,
    output krsf_cmd_t   cmd,
    output logic        busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_I_CHECK,
        S_I_HOLD,
        S_J_CHECK,
        S_J_CMP,
        S_SCAN_RD,
        S_SCAN_TAKE,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = S_I_CHECK;
                    end
                end
            end
            S_I_CHECK:
            begin
                if (stat.i_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_I_HOLD;
                end
            end
            S_I_HOLD:
            begin
                cmd.hold_take = 1'b1;
                state_next    = S_J_CHECK;
            end
            S_J_CHECK:
            begin
                if (stat.j_zero)
                begin
                    cmd.wr_held = 1'b1;
                    state_next  = S_I_CHECK;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_J_CMP;
                end
            end
            S_J_CMP:
            begin
                if (stat.move)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = S_J_CHECK;
                end
                else
                begin
                    cmd.wr_held = 1'b1;
                    state_next  = S_I_CHECK;
                end
            end
            S_SCAN_RD:
            begin
                state_next = stat.i_done ? S_FLUSH : S_SCAN_TAKE;
            end
            S_SCAN_TAKE:
            begin
                cmd.scan_take = 1'b1;
                state_next    = S_SCAN_RD;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/keyed_record_sort_filter_total.sv =====
// Top level: record store with stable sort by key and a category-filtered running total.
// Load item: its single result shows the cycle after, and a new item may follow at once.
// Report item: an insertion sort by key over the record memory (one read and one write port),
// then a filtered scan that gives one result per matching record, the final one with last set,
// or a single result without a record when none match.
// The receiver cannot stall; results come one per strobe. Reset (rst_n low) empties the store
// and sets ascending order and category 0; record memory contents are not cleared.
module keyed_record_sort_filter_total
    import krsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CAT_W-1:0]    cfg_wdata,
    input  logic                action,
    input  logic [KEY_W-1:0]    record_key,
    input  logic [COST_W-1:0]   cost_cents,
    input  logic [CAT_W-1:0]    category_code,
    output logic                result_valid,
    output logic [STAT_W-1:0]   status,
    output logic                has_record,
    output logic [KEY_W-1:0]    out_key,
    output logic [COST_W-1:0]   out_cost_cents,
    output logic [TOT_W-1:0]    running_total_cents,
    output logic                last
);

    // The controller only issues commands; all storage and arithmetic sit in the datapath.
    krsf_cmd_t  cmd;
    krsf_stat_t stat;

    krsf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the record memory, the sort indexes, the held record of the
    // insertion step and one pending report item so that the final one can carry last.
    krsf_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .record_key          (record_key),
        .cost_cents          (cost_cents),
        .category_code       (category_code),
        .result_valid        (result_valid),
        .status              (status),
        .has_record          (has_record),
        .out_key             (out_key),
        .out_cost_cents      (out_cost_cents),
        .running_total_cents (running_total_cents),
        .last                (last)
    );

    // An accepted load item gives its result in the very next cycle.
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_LOAD) |=> (result_valid && last))
        else $error("load item gave no result");

    // A report item keeps the block busy in the next cycle.
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_REPORT) |=> busy)
        else $error("report item did not start");

    // A result without a record is always the only and final one.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !has_record) |-> last)
        else $error("result without record is not final");

    // Load results never carry a record.
    a_load_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_REPORT) |-> (!has_record && last))
        else $error("load result carries a record");

endmodule
